/* rtl/rbf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, payload types, state encodings and the exponential table of the RBF kernel.
package rbf_pkg;

  // Coordinate stream
  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int SQ_W        = 2 * COORD_WIDTH;

  // Distance accumulator, Q32.16
  localparam int DIST_W = 48;
  localparam int ACC_W  = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Configuration registers
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SIGNAL = REG_IDX_W'(1);

  localparam int SCALE_W   = 16;
  localparam int SQSCALE_W = 2 * SCALE_W;
  localparam logic [SCALE_W-1:0] LENGTH_RESET = SCALE_W'(256);
  localparam logic [SCALE_W-1:0] SIGNAL_RESET = SCALE_W'(256);

  // Reciprocal floor(2^62 / L^2)
  localparam int RECIP_SHIFT = 62;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int DIV_CNT_W   = $clog2(RECIP_W);
  localparam logic [RECIP_W-1:0] RECIP_RESET =
    RECIP_W'((64'd1 << RECIP_SHIFT) / (64'(LENGTH_RESET) * 64'(LENGTH_RESET)));

  // Wide product D * R, split into partial products
  localparam int PROD_W     = DIST_W + RECIP_W;
  localparam int DLO_W      = DIST_W / 2;
  localparam int DHI_W      = DIST_W - DLO_W;
  localparam int RLO_W      = 32;
  localparam int PP_W       = DHI_W + RLO_W;
  localparam int MUL_STEPS  = 4;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);

  // Exponent path
  localparam int Q32          = 32;
  localparam int T16_LSB      = 47;
  localparam int T16_W        = 22;
  localparam int LOG2E_FRAC_W = 31;
  localparam logic [LOG2E_FRAC_W-1:0] LOG2E_FRAC = LOG2E_FRAC_W'(1901360723);
  localparam int LMUL_W       = T16_W + LOG2E_FRAC_W;
  localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;
  localparam int U_W          = T16_W + 1;
  localparam int FRAC_W       = 16;
  localparam int N_W          = U_W - FRAC_W;
  localparam int SHIFT_SEL_W  = 5;
  localparam int KV_W         = 32;

  // Table of 2^(-k/N) in Q32
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int EXP_IDX_W         = $clog2(EXP_TABLE_ENTRIES);
  localparam int KPROD_W           = FRAC_W + EXP_IDX_W + 1;
  localparam int EXP_W             = 33;
  localparam int SERIES_TERMS      = 20;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] LN2_Q32  = 64'd2977044472;

  // Queue between the accumulator and the exponential unit
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic                          last_element;
  } in_item_t;

  typedef struct packed {
    logic [KV_W-1:0] kernel_value;
    logic            saturated;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              ovf;
  } dist_item_t;

  typedef struct packed {
    logic [RECIP_W-1:0]   recip;
    logic [SQSCALE_W-1:0] sq_scale;
  } kparam_t;

  typedef enum logic [1:0] {
    CF_IDLE,
    CF_SQUARE,
    CF_DIV
  } cfg_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_LOG,
    BK_EXP,
    BK_TAB,
    BK_PRD,
    BK_SHIFT
  } bk_state_t;

  typedef logic [EXP_W-1:0] exp_tab_t [EXP_TABLE_ENTRIES];

  // e^(-k*ln2/N) by a truncated Taylor series in Q32
  function automatic exp_tab_t build_exp_table();
    exp_tab_t    tab;
    logic [63:0] xq;
    logic [63:0] z;
    logic [63:0] term;
    longint      sum;
    for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
      xq   = (64'(k) << Q32) / EXP_TABLE_ENTRIES;
      z    = (xq * LN2_Q32) >> Q32;
      term = ONE_Q32;
      sum  = longint'(ONE_Q32);
      for (int i = 1; i <= SERIES_TERMS; i++) begin
        term = ((term * z) >> Q32) / 64'(i);
        if (i % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      tab[k] = (sum < 0) ? '0 : EXP_W'(sum);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

/* rtl/rbf_cfg.sv */
`timescale 1ns / 1ps
// Register file, reciprocal divider and amplitude square of the RBF kernel.
module rbf_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbf_pkg::PADDR_W-1:0] paddr,
  input  logic [rbf_pkg::PDATA_W-1:0] pwdata,
  output logic [rbf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output rbf_pkg::kparam_t             kparam,
  output logic                         busy
);
  import rbf_pkg::*;

  cfg_state_t state_r, state_nxt;

  logic [SCALE_W-1:0]   length_r;
  logic [SCALE_W-1:0]   signal_r;
  logic [SQSCALE_W-1:0] s2_r;
  logic [SQSCALE_W-1:0] l2_r;
  logic [SQSCALE_W-1:0] rem_r;
  logic [SQSCALE_W-1:0] rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [RECIP_W-1:0]   recip_r;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr;
  logic                 wr_len;
  logic                 wr_sig;
  logic [SCALE_W-1:0]   l_sel;
  logic [SQSCALE_W:0]   rem_sh;
  logic [SQSCALE_W:0]   rem_sub;
  logic                 q_bit;
  logic                 l2_load;
  logic                 div_step;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign wr_len = wr && (idx == REG_LENGTH);
  assign wr_sig = wr && (idx == REG_SIGNAL);

  always_comb begin
    case (idx)
      REG_LENGTH: prdata = PDATA_W'(length_r);
      REG_SIGNAL: prdata = PDATA_W'(signal_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= LENGTH_RESET;
      signal_r <= SIGNAL_RESET;
    end else begin
      if (wr_len) length_r <= pwdata[SCALE_W-1:0];
      if (wr_sig) signal_r <= pwdata[SCALE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= SQSCALE_W'(signal_r) * SQSCALE_W'(signal_r);
  end

  // Restoring division of 2^62 by L^2, one quotient bit a cycle unless a length write restarts it
  assign l_sel   = (length_r == '0) ? SCALE_W'(1) : length_r;
  assign rem_sh  = {rem_r, (cnt_r == DIV_CNT_W'(RECIP_SHIFT))};
  assign rem_sub = rem_sh - (SQSCALE_W+1)'(l2_r);
  assign q_bit   = rem_sh >= (SQSCALE_W+1)'(l2_r);
  assign rem_nxt = q_bit ? rem_sub[SQSCALE_W-1:0] : rem_sh[SQSCALE_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CF_IDLE:   if (wr_len) state_nxt = CF_SQUARE;
      CF_SQUARE: state_nxt = wr_len ? CF_SQUARE : CF_DIV;
      CF_DIV: begin
        if (wr_len) begin
          state_nxt = CF_SQUARE;
        end else if (cnt_r == '0) begin
          state_nxt = CF_IDLE;
        end
      end
      default:   state_nxt = CF_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    l2_load  = 1'b0;
    div_step = 1'b0;
    case (state_r)
      CF_IDLE:   busy = 1'b0;
      CF_SQUARE: l2_load = 1'b1;
      CF_DIV:    div_step = !wr_len;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CF_IDLE;
      recip_r <= RECIP_RESET;
    end else begin
      state_r <= state_nxt;
      if (div_step) recip_r <= {recip_r[RECIP_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (l2_load) begin
      l2_r  <= SQSCALE_W'(l_sel) * SQSCALE_W'(l_sel);
      rem_r <= '0;
      cnt_r <= DIV_CNT_W'(RECIP_SHIFT);
    end else if (div_step) begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign kparam = '{recip: recip_r, sq_scale: s2_r};

  a_recip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (recip_r != '0))
    else $error("reciprocal is zero while idle");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CF_DIV) |-> (l2_r != '0))
    else $error("divider running with zero divisor");

endmodule

/* rtl/rbf_front.sv */
`timescale 1ns / 1ps
// Front end: squares coordinate differences and accumulates the saturating distance.
module rbf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rbf_pkg::in_item_t            in_data,
  input  logic                         busy,
  input  logic [rbf_pkg::Q_CNT_W-1:0] q_cnt,
  output logic                         q_push,
  output rbf_pkg::dist_item_t          q_wdata
);
  import rbf_pkg::*;

  logic                      s1_vld_r;
  logic                      s1_last_r;
  logic [SQ_W-1:0]           sq_r;
  logic [DIST_W-1:0]         sum_r, sum_nxt;
  logic                      ovf_r, ovf_nxt;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [2*DIFF_W-1:0] diff_sq;
  logic [ACC_W-1:0]           acc_sum;
  logic                       acc_over;
  logic [Q_CNT_W:0]           q_need;
  logic                       in_take;

  // A last item in the square stage already owns a queue slot
  assign q_need   = (Q_CNT_W+1)'(q_cnt) + (Q_CNT_W+1)'(s1_vld_r & s1_last_r);
  assign in_stall = busy || (q_need >= (Q_CNT_W+1)'(Q_DEPTH));
  assign in_take  = in_valid && !in_stall;

  assign diff    = DIFF_W'($signed(in_data.x_coord)) - DIFF_W'($signed(in_data.y_coord));
  assign diff_sq = diff * diff;

  always_ff @(posedge clk) begin
    if (in_take) begin
      sq_r      <= diff_sq[SQ_W-1:0];
      s1_last_r <= in_data.last_element;
    end
  end

  always_comb begin
    acc_sum  = ACC_W'(sum_r) + ACC_W'(sq_r);
    acc_over = acc_sum > ACC_W'(DIST_MAX);
    sum_nxt  = sum_r;
    ovf_nxt  = ovf_r;
    if (s1_vld_r) begin
      if (acc_over) begin
        sum_nxt = DIST_MAX;
        ovf_nxt = 1'b1;
      end else begin
        sum_nxt = acc_sum[DIST_W-1:0];
      end
    end
  end

  assign q_push  = s1_vld_r && s1_last_r;
  assign q_wdata = '{distance: sum_nxt, ovf: ovf_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      sum_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      s1_vld_r <= in_take;
      if (q_push) begin
        // hand the pair to the queue and start the next one from zero
        sum_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        sum_r <= sum_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

endmodule

/* rtl/rbf_queue.sv */
`timescale 1ns / 1ps
// Short queue of finished distances between the front end and the exponential unit.
module rbf_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  rbf_pkg::dist_item_t          wdata,
  input  logic                         pop,
  output rbf_pkg::dist_item_t          rdata,
  output logic                         valid,
  output logic [rbf_pkg::Q_CNT_W-1:0] cnt
);
  import rbf_pkg::*;

  dist_item_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign rdata = mem_r[rd_ptr_r];
  assign valid = cnt_r != '0;
  assign cnt   = cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < Q_CNT_W'(Q_DEPTH)))
    else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue read while empty");

endmodule

/* rtl/rbf_back.sv */
`timescale 1ns / 1ps
// Back end: scales the distance, evaluates the exponential and holds the result register.
module rbf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  rbf_pkg::dist_item_t  q_rdata,
  output logic                 q_pop,
  input  rbf_pkg::kparam_t     kparam,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rbf_pkg::out_item_t   out_data
);
  import rbf_pkg::*;

  bk_state_t state_r, state_nxt;

  logic [DIST_W-1:0]    d_r;
  logic                 sat_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [PP_W-1:0]      pp_r;
  logic [1:0]           ppsel_r;
  logic [PROD_W-1:0]    acc_r;
  logic [T16_W-1:0]     t16_r;
  logic [LMUL_W-1:0]    lmul_r;
  logic                 zero_r;
  logic [N_W-1:0]       n_r;
  logic [EXP_IDX_W-1:0] k_r;
  logic [EXP_W-1:0]     t_r;
  logic [63:0]          prod_r;
  logic                 out_vld_r;
  out_item_t            out_r;

  logic [DHI_W-1:0]   pa;
  logic [RLO_W-1:0]   pb;
  logic [PP_W-1:0]    pp_nxt;
  logic [PROD_W-1:0]  pp_shifted;
  logic [LMUL_W:0]    lmul_rnd;
  logic [U_W-1:0]     u16;
  logic [KPROD_W-1:0] k_prod;
  logic [KV_W-1:0]    kv;
  logic               out_free;
  logic               out_load;
  logic               mul_last;

  // Partial products: step bit 1 picks the distance half, bit 0 the reciprocal half
  assign pa = cnt_r[1] ? d_r[DIST_W-1:DLO_W] : DHI_W'(d_r[DLO_W-1:0]);
  assign pb = cnt_r[0] ? RLO_W'(kparam.recip[RECIP_W-1:RLO_W]) : kparam.recip[RLO_W-1:0];
  assign pp_nxt = PP_W'(pa) * PP_W'(pb);
  assign pp_shifted = (PROD_W'(pp_r) << (ppsel_r[0] ? RLO_W : 0)) << (ppsel_r[1] ? DLO_W : 0);
  assign mul_last = cnt_r == MUL_CNT_W'(MUL_STEPS);

  // u = t * log2(e), rounded; log2(e) is 1 plus a Q32 fraction that fits in 31 bits
  assign lmul_rnd = (LMUL_W+1)'(lmul_r) + (LMUL_W+1)'(ROUND_HALF);
  assign u16      = U_W'(t16_r) + U_W'(lmul_rnd >> Q32);
  assign k_prod   = KPROD_W'(u16[FRAC_W-1:0]) * KPROD_W'(EXP_TABLE_ENTRIES);

  assign kv = (zero_r || (|n_r[N_W-1:SHIFT_SEL_W])) ? '0 :
              (prod_r[63:Q32] >> n_r[SHIFT_SEL_W-1:0]);

  assign out_free = !out_vld_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (q_valid) state_nxt = BK_MUL;
      BK_MUL:   if (mul_last) state_nxt = BK_LOG;
      BK_LOG:   state_nxt = BK_EXP;
      BK_EXP:   state_nxt = BK_TAB;
      BK_TAB:   state_nxt = BK_PRD;
      BK_PRD:   state_nxt = BK_SHIFT;
      BK_SHIFT: if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      BK_IDLE:  q_pop = q_valid;
      BK_SHIFT: out_load = out_free;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      d_r   <= q_rdata.distance;
      sat_r <= q_rdata.ovf;
      acc_r <= '0;
      cnt_r <= '0;
    end
    if (state_r == BK_MUL) begin
      if (!mul_last) begin
        pp_r    <= pp_nxt;
        ppsel_r <= cnt_r[1:0];
      end
      // accumulate one step behind the multiplier
      if (cnt_r != '0) acc_r <= acc_r + pp_shifted;
      cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == BK_LOG) begin
      zero_r <= |acc_r[PROD_W-1:T16_LSB+T16_W];
      t16_r  <= acc_r[T16_LSB +: T16_W];
      lmul_r <= LMUL_W'(acc_r[T16_LSB +: T16_W]) * LMUL_W'(LOG2E_FRAC);
    end
    if (state_r == BK_EXP) begin
      n_r <= u16[U_W-1:FRAC_W];
      k_r <= k_prod[FRAC_W +: EXP_IDX_W];
    end
    if (state_r == BK_TAB) t_r <= EXP_TABLE[k_r];
    if (state_r == BK_PRD) begin
      // only the first entry reaches 2^32, and it has no lower bits
      prod_r <= t_r[EXP_W-1] ? {kparam.sq_scale, 32'b0} :
                64'(kparam.sq_scale) * 64'(t_r[31:0]);
    end
    if (out_load) out_r <= '{kernel_value: kv, saturated: sat_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

/* rtl/rbf_kernel_pair.sv */
`timescale 1ns / 1ps
// Squared-exponential kernel of one vector pair, streamed one coordinate pair per transaction.
// Input channel (in_valid/in_stall/in_data): x_coord, y_coord in signed Q8.8 and last_element.
// Every transaction adds (x - y)^2 to a saturating 48-bit distance; the transaction with
// last_element set closes the pair and yields one result on the output channel
// (out_valid/out_stall/out_data): kernel_value = s^2 * exp(-d / (2 l^2)) in unsigned Q16.16
// and saturated, set when the distance hit its ceiling.
// Throughput: one coordinate per cycle unless in_stall is high. The exponential unit takes one pair
// at a time (a 4-step partial-product multiply of distance by 1/(2 l^2), then log2(e) scaling, table
// lookup, amplitude multiply and shift), so short pairs are paced by it.
// A four-entry queue of finished distances lets the front keep accepting meanwhile.
// Registers via APB: length_scale at 0x0, signal_scale at 0x4. A length_scale write starts a
// bit-serial divide for 1/l^2; in_stall is high until it completes.
// Reset (rst_n low, synchronous) clears the distance, the queue and the result valid flag and
// loads l = s = 1.0; no divide runs after reset.
// A stalled result is held in the output register; the exponential unit waits behind it, and
// the input stalls only once the queue fills.
module rbf_kernel_pair (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rbf_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rbf_pkg::out_item_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rbf_pkg::PADDR_W-1:0] paddr,
  input  logic [rbf_pkg::PDATA_W-1:0] pwdata,
  output logic [rbf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import rbf_pkg::*;

  kparam_t            kparam;
  logic               busy;
  logic               q_push;
  logic               q_pop;
  logic               q_valid;
  dist_item_t         q_wdata;
  dist_item_t         q_rdata;
  logic [Q_CNT_W-1:0] q_cnt;

  rbf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .kparam  (kparam),
    .busy    (busy)
  );

  rbf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .busy     (busy),
    .q_cnt    (q_cnt),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  rbf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid),
    .cnt   (q_cnt)
  );

  rbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .kparam    (kparam),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/rbf_kernel_monitor.sv */
`timescale 1ns / 1ps
// Watches the RBF kernel channels and register port, predicts each pair's result and compares.
module rbf_kernel_monitor (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  rbf_pkg::in_item_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  rbf_pkg::out_item_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [rbf_pkg::PADDR_W-1:0] paddr,
  input  logic [rbf_pkg::PDATA_W-1:0] pwdata,
  output int unsigned                  errors,
  output int unsigned                  pending_results
);
  import rbf_pkg::*;

  localparam logic [63:0] LN2_FIX    = 64'd2977044472;
  localparam logic [63:0] LOG2E_FIX  = 64'd6196328019;
  localparam logic [63:0] UNITY_FIX  = 64'h1_0000_0000;
  localparam int          TAYLOR_N   = 20;
  localparam int          MAX_PRINTS = 25;

  logic [63:0]        pow2_frac [EXP_TABLE_ENTRIES];
  logic [SCALE_W-1:0] len_q88;
  logic [SCALE_W-1:0] amp_q88;
  logic [63:0]        inv_len_sq;
  logic [DIST_W-1:0]  dist_acc;
  logic               dist_clipped;
  out_item_t          kernel_due [$];

  // e^(-z), z in Q32, by alternating Taylor terms truncated at each step
  function automatic logic [63:0] exp_neg_series(logic [63:0] z);
    logic [63:0] term;
    longint      acc;
    term = UNITY_FIX;
    acc  = longint'(UNITY_FIX);
    for (int i = 1; i <= TAYLOR_N; i++) begin
      term = ((term * z) >> 32) / 64'(i);
      if (i % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  function automatic logic [63:0] inv_square(logic [SCALE_W-1:0] l);
    logic [63:0] lw;
    lw = (l == '0) ? 64'd1 : 64'(l);
    return (64'd1 << 62) / (lw * lw);
  endfunction

  function automatic logic [KV_W-1:0] rbf_value(logic [DIST_W-1:0] d);
    logic [127:0] scaled;
    logic [63:0]  t16;
    logic [63:0]  u16;
    logic [63:0]  n;
    logic [63:0]  k;
    logic [63:0]  amp_sq;
    scaled = 128'(d) * 128'(inv_len_sq);
    // d / (2 l^2) in Q.16; past this the exponential underflows to zero
    if ((scaled >> 47) >= 128'(64'd1 << 22)) return '0;
    t16 = 64'(scaled >> 47);
    u16 = (t16 * LOG2E_FIX + 64'h8000_0000) >> 32;
    n   = u16 >> 16;
    k   = ((u16 & 64'hFFFF) * EXP_TABLE_ENTRIES) >> 16;
    if (n >= 32) return '0;
    amp_sq = 64'(amp_q88) * 64'(amp_q88);
    return KV_W'((amp_sq * pow2_frac[k]) >> (32 + n));
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < MAX_PRINTS) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    errors++;
  endtask

  initial begin
    for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
      pow2_frac[k] = exp_neg_series((((64'(k) << 32) / EXP_TABLE_ENTRIES) * LN2_FIX) >> 32);
    end
  end

  always @(posedge clk) begin : track
    out_item_t   want;
    longint      dx;
    logic [63:0] sq;
    if (!rst_n) begin
      errors       = 0;
      len_q88      = LENGTH_RESET;
      amp_q88      = SIGNAL_RESET;
      inv_len_sq   = inv_square(LENGTH_RESET);
      dist_acc     = '0;
      dist_clipped = 1'b0;
      kernel_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (kernel_due.size() == 0) begin
          report_mismatch($sformatf("result %0h sat %0b with no pair pending",
                                    out_data.kernel_value, out_data.saturated));
        end else begin
          want = kernel_due.pop_front();
          if (out_data.kernel_value !== want.kernel_value) begin
            report_mismatch($sformatf("kernel_value %0h, expected %0h",
                                      out_data.kernel_value, want.kernel_value));
          end
          if (out_data.saturated !== want.saturated) begin
            report_mismatch($sformatf("saturated %0b, expected %0b",
                                      out_data.saturated, want.saturated));
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1:2] == REG_LENGTH) begin
          len_q88    = pwdata[SCALE_W-1:0];
          inv_len_sq = inv_square(len_q88);
        end else if (paddr[PADDR_W-1:2] == REG_SIGNAL) begin
          amp_q88 = pwdata[SCALE_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        dx = longint'($signed(in_data.x_coord)) - longint'($signed(in_data.y_coord));
        sq = 64'(dx * dx);
        // stick at the ceiling once the sum would overflow
        if (sq > 64'(DIST_MAX) - 64'(dist_acc)) begin
          dist_acc     = DIST_MAX;
          dist_clipped = 1'b1;
        end else begin
          dist_acc = dist_acc + DIST_W'(sq);
        end
        if (in_data.last_element) begin
          kernel_due.push_back('{kernel_value: rbf_value(dist_acc), saturated: dist_clipped});
          dist_acc     = '0;
          dist_clipped = 1'b0;
        end
      end
    end
    pending_results = kernel_due.size();
  end

endmodule

/* tb/tb_rbf_kernel_pair.sv */
`timescale 1ns / 1ps
// Top of the RBF kernel testbench: clock, reset, stimulus, stalls and the verdict.
module tb_rbf_kernel_pair;
  import rbf_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200_000;
  localparam int unsigned SETTLE_CYCLES   = 30;
  localparam int unsigned LONG_HOLD       = 80;
  localparam int unsigned PHASE_ITEMS     = 200;
  localparam int unsigned LONG_PAIR_ITEMS = 60;
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = 16'h7FFF;
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = 16'h8000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned errors;
  int unsigned pending_results;
  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  logic        in_taken    = 1'b0;
  logic        gaps_on;
  logic        hold_now;

  rbf_kernel_pair dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  rbf_kernel_monitor kernel_mon (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .errors          (errors),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    in_taken    <= in_valid && !in_stall;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: short random stall bursts, plus one long hold-off on request
  initial begin : result_side
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_now) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_now = 1'b0;
        out_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_coord(logic signed [COORD_WIDTH-1:0] x,
                            logic signed [COORD_WIDTH-1:0] y, logic last);
    in_item_t item;
    item.x_coord      = x;
    item.y_coord      = y;
    item.last_element = last;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // hold the transaction until the block takes it
    do @(negedge clk); while (!in_taken);
    items_sent++;
  endtask

  // One vector pair; y mostly near x so the kernel lands in its useful range
  task automatic send_pair(int unsigned len);
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] delta;
    int unsigned                   mag_bits;
    mag_bits = $urandom_range(0, 15);
    for (int unsigned i = 0; i < len; i++) begin
      x = COORD_WIDTH'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        y = COORD_WIDTH'($urandom);
      end else begin
        delta = COORD_WIDTH'($urandom & ((32'd1 << mag_bits) - 1));
        if ($urandom_range(0, 1) == 1) begin
          delta = -delta;
        end
        y = x + delta;
      end
      push_coord(x, y, i == len - 1);
    end
  endtask

  // Drain every pending result, then let the exponential unit go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [SCALE_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(PDATA_W - SCALE_W)'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(logic [SCALE_W-1:0] len, logic [SCALE_W-1:0] amp,
                           int unsigned count);
    int unsigned stop_at;
    settle();
    write_reg(REG_LENGTH, len);
    write_reg(REG_SIGNAL, amp);
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      send_pair(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8));
    end
  endtask

  initial begin : stimulus
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    gaps_on  = 1'b1;
    hold_now = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset scales: zero distance, extreme differences both ways, a multi-element pair
    push_coord('0, '0, 1'b1);
    push_coord(COORD_MAX, COORD_MIN, 1'b1);
    push_coord(COORD_MIN, COORD_MAX, 1'b1);
    push_coord(COORD_MIN, COORD_MIN, 1'b1);
    push_coord(COORD_MAX, COORD_MAX, 1'b1);
    push_coord(16'sd256, '0, 1'b0);
    push_coord('0, 16'sd256, 1'b0);
    push_coord(-16'sd256, '0, 1'b1);
    push_coord(16'sd1, '0, 1'b1);

    // Zero length scale acts as the smallest one
    settle();
    write_reg(REG_LENGTH, '0);
    write_reg(REG_SIGNAL, '1);
    push_coord('0, '0, 1'b1);
    push_coord(16'sd1, '0, 1'b1);
    push_coord(16'sd2, '0, 1'b1);

    settle();
    write_reg(REG_LENGTH, 16'd1);
    write_reg(REG_SIGNAL, '0);
    push_coord('0, '0, 1'b1);
    push_coord(16'sd1, '0, 1'b1);

    // Widest length scale, then a long pair of extreme differences
    settle();
    write_reg(REG_LENGTH, '1);
    write_reg(REG_SIGNAL, '1);
    push_coord(COORD_MAX, COORD_MIN, 1'b0);
    push_coord(COORD_MAX, COORD_MIN, 1'b1);
    gaps_on = 1'b0;
    for (int unsigned i = 0; i < LONG_PAIR_ITEMS; i++) begin
      push_coord(COORD_MAX, COORD_MIN, i == LONG_PAIR_ITEMS - 1);
    end
    push_coord('0, '0, 1'b1);
    gaps_on = 1'b1;

    // Back up the result side while short pairs keep coming
    settle();
    write_reg(REG_LENGTH, LENGTH_RESET);
    write_reg(REG_SIGNAL, SIGNAL_RESET);
    hold_now = 1'b1;
    repeat (40) send_pair(1);

    run_phase(LENGTH_RESET, SIGNAL_RESET, PHASE_ITEMS);
    run_phase('0, '1, PHASE_ITEMS);
    run_phase(16'd1, 16'd1, PHASE_ITEMS);
    run_phase('1, '1, PHASE_ITEMS);
    run_phase(16'd128, 16'd300, PHASE_ITEMS);
    run_phase(SCALE_W'($urandom_range(1, 65535)), SCALE_W'($urandom), PHASE_ITEMS);
    run_phase(SCALE_W'($urandom_range(16, 4096)), SCALE_W'($urandom), PHASE_ITEMS);
    settle();
    gaps_on = 1'b0;
    run_phase(SCALE_W'($urandom_range(64, 2048)), SCALE_W'($urandom), PHASE_ITEMS);
    settle();

    if (errors == 0 && pending_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rbf_pkg.sv
rtl/rbf_cfg.sv
rtl/rbf_front.sv
rtl/rbf_queue.sv
rtl/rbf_back.sv
rtl/rbf_kernel_pair.sv
tb/rbf_kernel_monitor.sv
tb/tb_rbf_kernel_pair.sv
